@@ hw/rtl/interval_partitioner_assert.svh @@
// Assertion macros for the interval partitioner.
`ifndef INTERVAL_PARTITIONER_ASSERT_SVH
`define INTERVAL_PARTITIONER_ASSERT_SVH

// Check that an implication holds at every clock edge outside reset.
`define IP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition holds at every clock edge outside reset.
`define IP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/ipart_pkg.sv @@
// Package with payload types and sequencer states for the interval partitioner.
`timescale 1ns / 1ps
package ipart_pkg;
  localparam int unsigned CoordW = 32;

  typedef struct packed {
    logic signed [CoordW-1:0] interval_low;
    logic signed [CoordW-1:0] interval_high;
    logic                     last_interval;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_low;
    logic signed [CoordW-1:0] out_high;
    logic [5:0]               partition_id;
    logic [6:0]               partition_count;
    logic                     overflow;
    logic                     last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_CUR,
    ST_SORT_CMP,
    ST_SORT_PLACE,
    ST_ASG_RD,
    ST_ASG_SCAN,
    ST_ASG_TEST_LO,
    ST_ASG_TEST_HI,
    ST_ASG_EMIT
  } state_e;
endpackage

@@ hw/rtl/interval_partitioner.sv @@
// Top level of the greedy interval partitioner: load, sort, assign and emit.
`timescale 1ns / 1ps
// Usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes intervals, one per cycle
//   while loading. The item carrying last_interval closes the set and starts
//   the run; in_ready_o stays low until the final result of the run is loaded
//   into the output register. Items beyond MAX_INTERVALS are dropped and flag
//   overflow on all results of that set.
//   out channel (out_valid_o/out_ready_i/out_data_o) returns one result per
//   kept interval in sorted order; the last one carries last_result and the
//   partition count.
// Timing: one shared signed comparator does all the work. The stable
//   insertion sort takes each element through read, latch, then a final
//   compare or place, plus a compare-and-move step for each slot the
//   element moves. The assignment takes each interval through read, a scan
//   of the open partitions (one partition per cycle), two overlap compares
//   and emit. The memory ports (one write, one registered read) set this.
// Reset: rst_ni clears the sequencer, counts and the overflow flag; the
//   interval stores keep no reset and are only read where written.
// Stall: a result waits in the output register while out_ready_i is low;
//   the sequencer holds in emit until the register frees up.
module interval_partitioner #(
  parameter int unsigned MAX_INTERVALS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ipart_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ipart_pkg::out_item_t out_data_o
);
  import ipart_pkg::*;

  localparam int unsigned IdxW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CntW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned W    = CoordW;

  // Interval store (sorted in place) and partition tail store.
  logic signed [W-1:0] st_lo_mem [MAX_INTERVALS];
  logic signed [W-1:0] st_hi_mem [MAX_INTERVALS];
  logic signed [W-1:0] pt_lo_mem [MAX_INTERVALS];
  logic signed [W-1:0] pt_hi_mem [MAX_INTERVALS];

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;     // stored intervals
  logic [CntW-1:0] parts_q, parts_d;     // open partitions
  logic            drop_q, drop_d;
  logic [CntW-1:0] i_q, i_d;             // outer index
  logic [CntW-1:0] k_q, k_d;             // sort slot / partition scan index
  logic [IdxW-1:0] best_q, best_d;
  logic signed [W-1:0] cur_lo_q, cur_lo_d, cur_hi_q, cur_hi_d;
  logic signed [W-1:0] bhi_q, bhi_d, blo_q, blo_d;
  logic            ovl_q, ovl_d;         // low end starts before best tail ends

  // Registered read ports.
  logic [IdxW-1:0] st_raddr, pt_raddr;
  logic signed [W-1:0] st_lo_rd_q, st_hi_rd_q, pt_lo_rd_q, pt_hi_rd_q;
  logic            st_we, pt_we;
  logic [IdxW-1:0] st_waddr, pt_waddr;
  logic signed [W-1:0] st_wlo, st_whi;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  // Shared signed comparator.
  logic signed [W-1:0] cmp_a, cmp_b;
  logic                cmp_lt;
  assign cmp_lt = cmp_a < cmp_b;

  logic in_fire;
  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_lo_mem[st_waddr] <= st_wlo;
      st_hi_mem[st_waddr] <= st_whi;
    end
    st_lo_rd_q <= st_lo_mem[st_raddr];
    st_hi_rd_q <= st_hi_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_lo_mem[pt_waddr] <= cur_lo_q;
      pt_hi_mem[pt_waddr] <= cur_hi_q;
    end
    pt_lo_rd_q <= pt_lo_mem[pt_raddr];
    pt_hi_rd_q <= pt_hi_mem[pt_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      parts_q     <= '0;
      drop_q      <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      parts_q     <= parts_d;
      drop_q      <= drop_d;
      i_q         <= i_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q   <= best_d;
    cur_lo_q <= cur_lo_d;
    cur_hi_q <= cur_hi_d;
    bhi_q    <= bhi_d;
    blo_q    <= blo_d;
    ovl_q    <= ovl_d;
    out_q    <= out_d;
  end

  always_comb begin
    logic [CntW-1:0] km1, kp1;
    logic            open_new;
    state_d = state_q;
    count_d = count_q;
    parts_d = parts_q;
    drop_d  = drop_q;
    i_d     = i_q;
    k_d     = k_q;
    best_d  = best_q;
    cur_lo_d = cur_lo_q;
    cur_hi_d = cur_hi_q;
    bhi_d   = bhi_q;
    blo_d   = blo_q;
    ovl_d   = ovl_q;
    out_valid_d = out_valid_q;
    out_d   = out_q;
    st_we   = 1'b0;
    st_waddr = count_q[IdxW-1:0];
    st_wlo  = in_data_i.interval_low;
    st_whi  = in_data_i.interval_high;
    st_raddr = '0;
    pt_we   = 1'b0;
    pt_waddr = best_q;
    pt_raddr = '0;
    cmp_a   = cur_hi_q;
    cmp_b   = st_hi_rd_q;
    km1     = k_q - CntW'(1);
    kp1     = k_q + CntW'(1);
    open_new = 1'b0;
    // Free the output register on its transfer.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (count_q < CntW'(MAX_INTERVALS)) begin
            st_we   = 1'b1;
            count_d = count_q + CntW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (in_data_i.last_interval) begin
            i_d = CntW'(1);
            state_d = ST_SORT_RD;
          end
        end
      end
      // Insertion sort: take element i, shift larger ones up.
      ST_SORT_RD: begin
        st_raddr = i_q[IdxW-1:0];
        k_d = i_q;
        if (i_q >= count_q) begin
          i_d = '0;
          parts_d = '0;
          state_d = (count_q == '0) ? ST_LOAD : ST_ASG_RD;
          if (count_q == '0) begin
            drop_d = 1'b0;
          end
        end else begin
          state_d = ST_SORT_CUR;
        end
      end
      ST_SORT_CUR: begin
        // Latch the element to insert and fetch its left neighbor.
        cur_lo_d = st_lo_rd_q;
        cur_hi_d = st_hi_rd_q;
        st_raddr = km1[IdxW-1:0];
        state_d = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        // st_*_rd_q holds slot k-1; move it up while current sorts before it.
        if (cur_lo_q == st_lo_rd_q) begin
          cmp_a = cur_hi_q;
          cmp_b = st_hi_rd_q;
        end else begin
          cmp_a = cur_lo_q;
          cmp_b = st_lo_rd_q;
        end
        st_we = 1'b1;
        st_waddr = k_q[IdxW-1:0];
        if (cmp_lt) begin
          st_wlo = st_lo_rd_q;
          st_whi = st_hi_rd_q;
          k_d = km1;
          if (km1 == '0) begin
            state_d = ST_SORT_PLACE;
          end else begin
            st_raddr = km1[IdxW-1:0] - IdxW'(1);
          end
        end else begin
          st_wlo = cur_lo_q;
          st_whi = cur_hi_q;
          i_d = i_q + CntW'(1);
          state_d = ST_SORT_RD;
        end
      end
      ST_SORT_PLACE: begin
        // Current sorts before everything: drop it into slot zero.
        st_we = 1'b1;
        st_waddr = k_q[IdxW-1:0];
        st_wlo = cur_lo_q;
        st_whi = cur_hi_q;
        i_d = i_q + CntW'(1);
        state_d = ST_SORT_RD;
      end
      ST_ASG_RD: begin
        st_raddr = i_q[IdxW-1:0];
        k_d = '0;
        pt_raddr = '0;
        state_d = ST_ASG_SCAN;
      end
      ST_ASG_SCAN: begin
        // pt_*_rd_q holds the tail of partition k; keep the earliest end.
        if (k_q == '0) begin
          cur_lo_d = st_lo_rd_q;
          cur_hi_d = st_hi_rd_q;
        end
        if (k_q < parts_q) begin
          cmp_a = pt_hi_rd_q;
          cmp_b = bhi_q;
          if (k_q == '0 || cmp_lt) begin
            best_d = k_q[IdxW-1:0];
            bhi_d = pt_hi_rd_q;
            blo_d = pt_lo_rd_q;
          end
          pt_raddr = kp1[IdxW-1:0];
          k_d = kp1;
          if (kp1 >= parts_q) begin
            state_d = ST_ASG_TEST_LO;
          end
        end else begin
          state_d = ST_ASG_TEST_LO;
        end
      end
      ST_ASG_TEST_LO: begin
        // Overlap needs lo < best tail high ...
        cmp_a = cur_lo_q;
        cmp_b = bhi_q;
        ovl_d = cmp_lt;
        state_d = ST_ASG_TEST_HI;
      end
      ST_ASG_TEST_HI: begin
        // ... and best tail low < hi.
        cmp_a = blo_q;
        cmp_b = cur_hi_q;
        if (parts_q == '0) begin
          open_new = 1'b1;
        end else if (ovl_q && cmp_lt) begin
          open_new = 1'b1;
        end
        if (open_new) begin
          best_d = (parts_q >= CntW'(MAX_INTERVALS)) ? IdxW'(MAX_INTERVALS - 1)
                                                     : parts_q[IdxW-1:0];
          if (parts_q < CntW'(MAX_INTERVALS)) begin
            parts_d = parts_q + CntW'(1);
          end
        end
        state_d = ST_ASG_EMIT;
      end
      ST_ASG_EMIT: begin
        // Hold until the output register is free, then record the new tail.
        if (!out_valid_q || out_ready_i) begin
          pt_we = 1'b1;
          out_valid_d = 1'b1;
          out_d.out_low  = cur_lo_q;
          out_d.out_high = cur_hi_q;
          out_d.partition_id = 6'(best_q);
          out_d.overflow = drop_q;
          if (i_q + CntW'(1) >= count_q) begin
            out_d.partition_count = 7'(parts_q);
            out_d.last_result = 1'b1;
            i_d = '0;
            count_d = '0;
            parts_d = '0;
            drop_d = 1'b0;
            state_d = ST_LOAD;
          end else begin
            out_d.partition_count = '0;
            out_d.last_result = 1'b0;
            i_d = i_q + CntW'(1);
            state_d = ST_ASG_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  `include "interval_partitioner_assert.svh"

  `IP_ASSERT_IMPL(a_ready_only_load, clk_i, rst_ni, in_ready_o, state_q == ST_LOAD)
  `IP_ASSERT_ALWAYS(a_count_cap, clk_i, rst_ni, count_q <= CntW'(MAX_INTERVALS))
  `IP_ASSERT_ALWAYS(a_parts_cap, clk_i, rst_ni, parts_q <= count_q)
  `IP_ASSERT_IMPL(a_best_open, clk_i, rst_ni, state_q == ST_ASG_EMIT, CntW'(best_q) < parts_q)
endmodule
